/* src/rotary_encoder_counter_macros.svh */
// Assertion macros used by the rotary encoder counter checker.
`ifndef ROTARY_ENCODER_COUNTER_MACROS_SVH
`define ROTARY_ENCODER_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define REC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary encoder counter: implication failed");

// Next-cycle implication, disabled while reset is high
`define REC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotary encoder counter: next-cycle check failed");

// Next-cycle implication that also runs through reset
`define REC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rotary encoder counter: reset check failed");

`endif

/* src/rec_pkg.sv */
// Shared types, constants and step function for the rotary encoder counter.
`default_nettype none

package rec_pkg;

  // Request kinds on the input stream
  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_SET  = 2'd2,
    CMD_PLUS = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COUNT_MAX    = 3'd0,
    REG_CW_MAX       = 3'd1,
    REG_CCW_MAX      = 3'd2,
    REG_REVERSE_DIR  = 3'd3,
    REG_SNAP_EVEN    = 3'd4,
    REG_SETTLE_TICKS = 3'd5,
    REG_EVEN_DELAY   = 3'd6,
    REG_SPEED_CAP    = 3'd7
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

  // Register reset values
  localparam logic [7:0] RST_COUNT_MAX    = 8'd30;
  localparam logic [7:0] RST_CW_MAX       = 8'd63;
  localparam logic [7:0] RST_CCW_MAX      = 8'd63;
  localparam logic       RST_REVERSE_DIR  = 1'b1;
  localparam logic       RST_SNAP_EVEN    = 1'b0;
  localparam logic [3:0] RST_SETTLE_TICKS = 4'd2;
  localparam logic [5:0] RST_EVEN_DELAY   = 6'd25;
  localparam logic [6:0] RST_SPEED_CAP    = 7'd80;

  // Speed arithmetic: speed = SPEED_NUM / gap, gaps over SLOW_GAP_MS give 1
  localparam int unsigned SLOW_GAP_MS = 250;
  localparam int unsigned SPEED_NUM   = 500;
  localparam int unsigned DIV_W       = 9;   // quotient width, holds SPEED_NUM
  localparam int unsigned DIV_STEP_W  = 4;   // holds DIV_W

  // Stream widths
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_DATA_W = 32;
  localparam int unsigned M_USER_W = 2;

  // Result of one position step
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] cw_cnt;
    logic [7:0] ccw_cnt;
    logic       dir;
  } step_t;

  // One step of the position and the matching step counter
  function automatic step_t take_step(input logic [7:0] cnt,
                                      input logic [7:0] cwc,
                                      input logic [7:0] ccwc,
                                      input logic       cw,
                                      input logic [7:0] cmax,
                                      input logic [7:0] cwmax,
                                      input logic [7:0] ccwmax);
    step_t r;
    r.count   = cnt;
    r.cw_cnt  = cwc;
    r.ccw_cnt = ccwc;
    r.dir     = cw;
    if (cw) begin
      r.count  = (cnt >= cmax) ? 8'd0 : cnt + 8'd1;
      r.cw_cnt = (cwc >= cwmax) ? 8'd0 : cwc + 8'd1;
    end else begin
      r.count   = (cnt == 8'd0 || (cnt - 8'd1) > cmax) ? cmax : cnt - 8'd1;
      r.ccw_cnt = (ccwc >= ccwmax) ? 8'd0 : ccwc + 8'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/rotary_encoder_counter.sv */
// Top level of the multi-channel rotary encoder counter.
//
//  Channel  Dir  Ports                         Contents (low bit first)
//  in       in   s_tvalid s_tready s_tdata/user tdata: pin_a, pin_b, now_ms, set_value
//                                               tuser: cmd, chan
//  out      out  m_tvalid m_tready m_tdata/user tdata: position, cw_steps, ccw_steps,
//                                               direction, speed; tuser: out_chan, changed
//  config   in   cfg_we cfg_index cfg_data      one register per write
//
// Each request passes through the accept, update and result states; a tick that
// samples a step with a gap of 1 to 250 ms also runs the 9-step speed divider in between.
// One request is in work at a time; the next is taken while the result waits
// in the output register. A stalled output holds the sequencer in its last state.
// Synchronous reset clears all channel state and loads the register defaults.
`default_nettype none

module rotary_encoder_counter #(
  parameter int CHANNELS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rec_pkg::S_DATA_W-1:0]  s_tdata,  // pin_a, pin_b, now_ms, set_value
  input  wire logic [rec_pkg::S_USER_W-1:0]  s_tuser,  // cmd, chan
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rec_pkg::M_DATA_W-1:0]       m_tdata,  // position, cw, ccw, direction, speed
  output logic [rec_pkg::M_USER_W-1:0]       m_tuser,  // out_chan, changed
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import rec_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_CNT = 5'(CHANNELS);

  // Configuration registers
  logic [7:0] count_max, cw_max, ccw_max;
  logic       reverse_dir, snap_even;
  logic [3:0] settle_ticks;
  logic [5:0] even_delay;
  logic [6:0] speed_cap;

  // Per-channel state
  logic [6:0]  settle_phase   [CHANNELS];
  logic [7:0]  count_reg      [CHANNELS];
  logic [7:0]  reported_count [CHANNELS];
  logic [7:0]  cw_count       [CHANNELS];
  logic [7:0]  ccw_count      [CHANNELS];
  logic        last_dir       [CHANNELS];
  logic [6:0]  speed_reg      [CHANNELS];
  logic [31:0] last_step_time [CHANNELS];

  // Latched request
  cmd_t        item_cmd;
  logic        item_chan;
  logic        item_pin_a, item_pin_b;
  logic [31:0] item_now;
  logic [7:0]  item_sv;
  logic        changed;

  state_t state, state_next;

  logic [IDX_W-1:0] idx;
  logic             chan_ok;

  // Update path
  logic [6:0]  cur_phase, ph_inc, trig_pt1, trig_pt2;
  logic        hit_sample, hit_snap, sampled_cw, need_div;
  logic [31:0] dt;
  step_t       step_res;
  logic [6:0]  phase_next;
  logic [7:0]  count_next, rep_next, cw_next, ccw_next, sv_clamp;
  logic        dir_next, changed_next, time_upd;
  logic [6:0]  speed_next;

  // Divider hookup and sequencer outputs
  logic              div_start, div_busy, spd_load, out_load, out_free;
  logic [DIV_W-1:0]  div_q;
  logic [6:0]        div_speed;

  assign idx     = IDX_W'(item_chan);
  assign chan_ok = {4'd0, item_chan} < CH_CNT;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_max    <= RST_COUNT_MAX;
      cw_max       <= RST_CW_MAX;
      ccw_max      <= RST_CCW_MAX;
      reverse_dir  <= RST_REVERSE_DIR;
      snap_even    <= RST_SNAP_EVEN;
      settle_ticks <= RST_SETTLE_TICKS;
      even_delay   <= RST_EVEN_DELAY;
      speed_cap    <= RST_SPEED_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_MAX:    count_max    <= cfg_data;
        REG_CW_MAX:       cw_max       <= cfg_data;
        REG_CCW_MAX:      ccw_max      <= cfg_data;
        REG_REVERSE_DIR:  reverse_dir  <= cfg_data[0];
        REG_SNAP_EVEN:    snap_even    <= cfg_data[0];
        REG_SETTLE_TICKS: settle_ticks <= cfg_data[3:0];
        REG_EVEN_DELAY:   even_delay   <= cfg_data[5:0];
        REG_SPEED_CAP:    speed_cap    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_cmd   <= cmd_t'(s_tuser[1:0]);
      item_chan  <= s_tuser[2];
      item_pin_a <= s_tdata[0];
      item_pin_b <= s_tdata[1];
      item_now   <= s_tdata[33:2];
      item_sv    <= s_tdata[41:34];
    end
  end

  // Phase tracking and trigger points
  always_comb begin
    cur_phase  = settle_phase[idx];
    ph_inc     = (cur_phase != 7'd0) ? cur_phase + 7'd1 : 7'd0;
    trig_pt1   = {3'd0, settle_ticks} + 7'd1;
    trig_pt2   = trig_pt1 + {1'b0, even_delay};
    hit_sample = (item_cmd == CMD_TICK) && ph_inc != 7'd0 && ph_inc == trig_pt1;
    hit_snap   = (item_cmd == CMD_TICK) && !hit_sample && ph_inc != 7'd0
                 && ph_inc == trig_pt2;
    sampled_cw = (item_pin_a == item_pin_b) ^ reverse_dir;
    dt         = item_now - last_step_time[idx];
    step_res   = take_step(count_reg[idx], cw_count[idx], ccw_count[idx],
                           hit_sample ? sampled_cw : last_dir[idx],
                           count_max, cw_max, ccw_max);
    sv_clamp   = (item_sv > count_max) ? count_max : item_sv;
  end

  // Next channel state for the request
  always_comb begin
    phase_next   = cur_phase;
    count_next   = count_reg[idx];
    rep_next     = reported_count[idx];
    cw_next      = cw_count[idx];
    ccw_next     = ccw_count[idx];
    dir_next     = last_dir[idx];
    speed_next   = speed_reg[idx];
    changed_next = 1'b0;
    time_upd     = 1'b0;
    need_div     = 1'b0;
    unique case (item_cmd)
      CMD_EDGE: begin
        phase_next = 7'd1;
      end
      CMD_TICK: begin
        if (hit_sample) begin
          phase_next = snap_even ? ph_inc : 7'd0;
        end else if (hit_snap) begin
          phase_next = 7'd0;
        end else begin
          phase_next = ph_inc;
        end
        if (hit_sample || hit_snap) begin
          count_next = step_res.count;
          cw_next    = step_res.cw_cnt;
          ccw_next   = step_res.ccw_cnt;
          dir_next   = step_res.dir;
        end
        if (hit_snap) begin
          count_next = {step_res.count[7:1], 1'b0};
        end
        // Speed from the gap since the previous step
        if (hit_sample) begin
          time_upd = 1'b1;
          if (dt > 32'(SLOW_GAP_MS)) begin
            speed_next = 7'd1;
          end else if (dt == 32'd0) begin
            speed_next = (speed_reg[idx] > speed_cap) ? speed_cap : speed_reg[idx];
          end else begin
            need_div = 1'b1;
          end
        end
        // An even snap always reports
        changed_next = hit_snap || (count_next != reported_count[idx]);
        rep_next     = count_next;
      end
      CMD_SET: begin
        count_next = sv_clamp;
        rep_next   = sv_clamp;
      end
      CMD_PLUS: begin
        count_next = (count_reg[idx] >= count_max) ? 8'd0 : count_reg[idx] + 8'd1;
        rep_next   = count_next;
      end
      default: ;
    endcase
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        settle_phase[i]   <= '0;
        count_reg[i]      <= '0;
        reported_count[i] <= '0;
        cw_count[i]       <= '0;
        ccw_count[i]      <= '0;
        last_dir[i]       <= 1'b0;
        speed_reg[i]      <= '0;
        last_step_time[i] <= '0;
      end
    end else if (state == ST_EXEC && chan_ok) begin
      settle_phase[idx]   <= phase_next;
      count_reg[idx]      <= count_next;
      reported_count[idx] <= rep_next;
      cw_count[idx]       <= cw_next;
      ccw_count[idx]      <= ccw_next;
      last_dir[idx]       <= dir_next;
      speed_reg[idx]      <= speed_next;
      if (time_upd) begin
        last_step_time[idx] <= item_now;
      end
    end else if (spd_load) begin
      speed_reg[idx] <= div_speed;
    end
  end

  // Report flag for the result
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      changed <= chan_ok && changed_next;
    end
  end

  // Shared divider
  rec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(SPEED_NUM)),
    .divisor  (dt[DIV_W-2:0]),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign div_speed = (div_q > {2'b00, speed_cap}) ? speed_cap : div_q[6:0];

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = (chan_ok && need_div) ? ST_DIV : ST_DONE;
      ST_DIV:  if (!div_busy) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    spd_load  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_EXEC: div_start = chan_ok && need_div;
      ST_DIV:  spd_load  = !div_busy;
      ST_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= {changed, item_chan};
      if (chan_ok) begin
        m_tdata <= {speed_reg[idx], last_dir[idx], ccw_count[idx],
                    cw_count[idx], count_reg[idx]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/rec_div.sv */
// Restoring divider, one quotient bit per cycle, used for the speed.
`default_nettype none

module rec_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rec_pkg::DIV_W-1:0]  dividend,
  input  wire logic [rec_pkg::DIV_W-2:0]  divisor,
  output logic                            busy,
  output logic [rec_pkg::DIV_W-1:0]       quotient
);
  import rec_pkg::*;

  logic [DIV_W-2:0]      rem;
  logic [DIV_W-2:0]      dvs;
  logic [DIV_W-1:0]      quo;
  logic [DIV_STEP_W-1:0] steps;
  logic [DIV_W-1:0]      trial;
  logic [DIV_W-1:0]      diff;
  logic                  fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_STEP_W'(DIV_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == DIV_STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register; remainder stays below the divisor.
  // The divisor is held from the start, as its source moves on straight after.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-2:0] : trial[DIV_W-2:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* src/rec_checker.sv */
// Port-level checks for the rotary encoder counter, bound to the top level.
`default_nettype none

`include "rotary_encoder_counter_macros.svh"

module rec_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [rec_pkg::M_DATA_W-1:0]  m_tdata,
  input wire logic [rec_pkg::M_USER_W-1:0]  m_tuser
);

  // A stalled result holds
  `REC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Only one request in work: the input closes right after an accept
  `REC_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

  // A request cannot produce its result in the cycle after it is taken
  `REC_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

  // Reset empties the output and opens the input
  `REC_ASSERT_NEXT_ALWAYS(a_reset_state, rst, !m_tvalid && s_tready)

endmodule

bind rotary_encoder_counter rec_checker u_rec_checker (.*);

`default_nettype wire

/* dv/tb.sv */
// Self-checking stream testbench for the multi-channel rotary encoder counter.
`timescale 1ns / 100ps

module tb;
  import rec_pkg::*;

  // Request and result as seen on the streams
  typedef struct {
    cmd_t        cmd;
    logic        chan;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
    logic [7:0]  set_value;
  } enc_req_t;

  typedef struct {
    logic       chan;
    logic [7:0] position;
    logic [7:0] cw_steps;
    logic [7:0] ccw_steps;
    logic       direction;
    logic [6:0] speed;
    logic       changed;
  } enc_rep_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;  // pin_a, pin_b, now_ms, set_value
  logic [S_USER_W-1:0] s_tuser   = '0;  // cmd, chan
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // position, cw_steps, ccw_steps, direction, speed
  logic [M_USER_W-1:0] m_tuser;         // out_chan, changed
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [7:0]          cfg_data  = '0;

  rotary_encoder_counter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Decoder configuration as the block holds it
  logic [7:0] lim_count  = RST_COUNT_MAX;
  logic [7:0] lim_cw     = RST_CW_MAX;
  logic [7:0] lim_ccw    = RST_CCW_MAX;
  logic       lim_rev    = RST_REVERSE_DIR;
  logic       lim_snap   = RST_SNAP_EVEN;
  logic [3:0] lim_settle = RST_SETTLE_TICKS;
  logic [5:0] lim_delay  = RST_EVEN_DELAY;
  logic [6:0] lim_cap    = RST_SPEED_CAP;

  // Per-channel decoder state
  logic [6:0]  phase_q[2]  = '{default: '0};
  logic [7:0]  pos_q[2]    = '{default: '0};
  logic [7:0]  shown_q[2]  = '{default: '0};
  logic [7:0]  cw_q[2]     = '{default: '0};
  logic [7:0]  ccw_q[2]    = '{default: '0};
  logic        dir_q[2]    = '{default: '0};
  logic [6:0]  speed_q[2]  = '{default: '0};
  logic [31:0] stamp_q[2]  = '{default: '0};

  enc_req_t pending_req_q[$];
  enc_rep_t report_due_q[$];
  enc_req_t on_bus;
  enc_rep_t due;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   hold_req       = 1'b0;
  bit   hold_done;
  int   hold_cnt;
  int   mismatch_n     = 0;
  int   queued_n       = 0;
  logic [31:0] ms_now  = '0;
  bit   freeze_ms      = 1'b0;

  // One position step in the given direction, with its step counter
  function automatic void step_position(int c, logic cw);
    if (cw) begin
      pos_q[c] = (pos_q[c] >= lim_count) ? 8'd0 : pos_q[c] + 8'd1;
      cw_q[c]  = (cw_q[c] >= lim_cw) ? 8'd0 : cw_q[c] + 8'd1;
    end else begin
      pos_q[c] = (pos_q[c] == 8'd0 || pos_q[c] - 8'd1 > lim_count) ? lim_count
                                                                 : pos_q[c] - 8'd1;
      ccw_q[c] = (ccw_q[c] >= lim_ccw) ? 8'd0 : ccw_q[c] + 8'd1;
    end
    dir_q[c] = cw;
  endfunction

  // Pin sample: decode direction, step, and rework the speed from the gap
  function automatic void sample_pins(int c, logic a, logic b, logic [31:0] now);
    logic [31:0] gap;
    int unsigned sp;
    step_position(c, (a == b) ^ lim_rev);
    gap        = now - stamp_q[c];
    stamp_q[c] = now;
    sp         = speed_q[c];
    if (gap > SLOW_GAP_MS) begin
      sp = 1;
    end else begin
      if (gap != 0) sp = SPEED_NUM / gap;
      if (sp > lim_cap) sp = lim_cap;
    end
    speed_q[c] = sp[6:0];
  endfunction

  // Expected report for one accepted request; updates the channel state
  function automatic enc_rep_t predict_report(enc_req_t rq);
    enc_rep_t   rep;
    int         c;
    int         sample_pt;
    int         snap_pt;
    logic [6:0] ph;
    logic [7:0] sv;
    c         = rq.chan;
    sample_pt = lim_settle + 1;
    snap_pt   = sample_pt + lim_delay;
    rep.changed = 1'b0;
    case (rq.cmd)
      CMD_EDGE: phase_q[c] = 7'd1;
      CMD_TICK: begin
        ph = phase_q[c];
        if (ph != 0) ph = ph + 7'd1;
        if (ph != 0 && ph == sample_pt) begin
          if (!lim_snap) ph = '0;
          phase_q[c] = ph;
          sample_pins(c, rq.pin_a, rq.pin_b, rq.now_ms);
        end else if (ph != 0 && ph == snap_pt) begin
          // delayed extra step, rounded down to even, always reported
          phase_q[c] = '0;
          step_position(c, dir_q[c]);
          pos_q[c][0] = 1'b0;
          shown_q[c]  = pos_q[c] - 8'd1;
        end else begin
          phase_q[c] = ph;
        end
        if (pos_q[c] != shown_q[c]) begin
          shown_q[c]  = pos_q[c];
          rep.changed = 1'b1;
        end
      end
      CMD_SET: begin
        sv = (rq.set_value > lim_count) ? lim_count : rq.set_value;
        pos_q[c]   = sv;
        shown_q[c] = sv;
      end
      default: begin
        pos_q[c]   = (pos_q[c] >= lim_count) ? 8'd0 : pos_q[c] + 8'd1;
        shown_q[c] = pos_q[c];
      end
    endcase
    rep.chan      = rq.chan;
    rep.position  = pos_q[c];
    rep.cw_steps  = cw_q[c];
    rep.ccw_steps = ccw_q[c];
    rep.direction = dir_q[c];
    rep.speed     = speed_q[c];
    return rep;
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_n++;
    if (mismatch_n <= 30) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) report_due_q.push_back(predict_report(on_bus));
      if (!s_tvalid || s_tready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus   = pending_req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, on_bus.set_value, on_bus.now_ms, on_bus.pin_b, on_bus.pin_a};
          s_tuser  <= {on_bus.chan, on_bus.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (report_due_q.size() == 0) begin
        log_mismatch("result with no request outstanding");
      end else begin
        due = report_due_q.pop_front();
        check_field("out_chan", m_tuser[0], due.chan);
        check_field("position", m_tdata[7:0], due.position);
        check_field("cw_steps", m_tdata[15:8], due.cw_steps);
        check_field("ccw_steps", m_tdata[23:16], due.ccw_steps);
        check_field("direction", m_tdata[24], due.direction);
        check_field("speed", m_tdata[31:25], due.speed);
        check_field("changed", m_tuser[1], due.changed);
      end
    end
  end

  task automatic push_item(cmd_t cmd, logic chan, logic a, logic b, logic [31:0] now,
                           logic [7:0] sv);
    enc_req_t rq;
    rq.cmd       = cmd;
    rq.chan      = chan;
    rq.pin_a     = a;
    rq.pin_b     = b;
    rq.now_ms    = now;
    rq.set_value = sv;
    pending_req_q.push_back(rq);
    queued_n++;
  endtask

  // Millisecond clock for random requests: mostly short gaps, some long, some jumps
  function automatic logic [31:0] next_ms();
    int r;
    if (!freeze_ms) begin
      r = $urandom_range(99);
      if (r < 15)      ms_now = ms_now;
      else if (r < 65) ms_now = ms_now + $urandom_range(5, 1);
      else if (r < 88) ms_now = ms_now + $urandom_range(60, 6);
      else if (r < 98) ms_now = ms_now + $urandom_range(400, 200);
      else             ms_now = $urandom;
    end
    return ms_now;
  endfunction

  task automatic push_noise(logic chan);
    push_item(cmd_t'($urandom_range(3)), chan, $urandom_range(1), $urandom_range(1),
              next_ms(), $urandom_range(255));
  endtask

  // Random traffic: mostly complete edge/tick sequences, some cut short, some noise
  task automatic fill_random(int budget);
    int   start;
    int   kind;
    int   ticks;
    logic c;
    start = queued_n;
    while (queued_n - start < budget) begin
      c         = $urandom_range(1);
      freeze_ms = ($urandom_range(9) == 0);
      kind      = $urandom_range(99);
      if (kind < 70) begin
        ticks = lim_settle + 1;
        if (lim_snap && $urandom_range(3) != 0) ticks += lim_delay;
      end else if (kind < 85) begin
        ticks = $urandom_range(lim_settle);
      end else begin
        ticks = -1;
      end
      if (ticks < 0) begin
        push_noise($urandom_range(1));
      end else begin
        push_item(CMD_EDGE, c, $urandom_range(1), $urandom_range(1), next_ms(),
                  $urandom_range(255));
        for (int i = 0; i < ticks; i++) begin
          if ($urandom_range(99) < 12) push_noise(~c);
          push_item(CMD_TICK, c, $urandom_range(1), $urandom_range(1), next_ms(),
                    $urandom_range(255));
        end
      end
    end
    freeze_ms = 1'b0;
  endtask

  // Block idle: nothing queued, nothing on the bus, every result back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_req_q.size() != 0 || s_tvalid || report_due_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    case (idx)
      REG_COUNT_MAX:    lim_count  = val;
      REG_CW_MAX:       lim_cw     = val;
      REG_CCW_MAX:      lim_ccw    = val;
      REG_REVERSE_DIR:  lim_rev    = val[0];
      REG_SNAP_EVEN:    lim_snap   = val[0];
      REG_SETTLE_TICKS: lim_settle = val[3:0];
      REG_EVEN_DELAY:   lim_delay  = val[5:0];
      default:          lim_cap    = val[6:0];
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Stimulus and phase sequencing
  initial begin
    logic [7:0] setting[8];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: clamps, wraps, zero gap, slow gap, time wrap, edge during settle
    push_item(CMD_SET,  1'b0, 1'b0, 1'b0, 32'd0, 8'hFF);
    push_item(CMD_PLUS, 1'b0, 1'b1, 1'b1, 32'd0, 8'h00);
    push_item(CMD_PLUS, 1'b1, 1'b0, 1'b1, 32'd0, 8'h00);
    push_item(CMD_TICK, 1'b1, 1'b1, 1'b0, 32'd0, 8'h00);
    push_item(CMD_EDGE, 1'b0, 1'b0, 1'b0, 32'd1000, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd1000, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 32'd1000, 8'h00);
    push_item(CMD_EDGE, 1'b0, 1'b0, 1'b0, 32'd1000, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd1000, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b0, 1'b1, 32'd1000, 8'h00);
    push_item(CMD_EDGE, 1'b0, 1'b0, 1'b0, 32'd1001, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd1001, 8'h00);
    push_item(CMD_EDGE, 1'b0, 1'b0, 1'b0, 32'd1001, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd1002, 8'h00);
    push_item(CMD_TICK, 1'b0, 1'b1, 1'b0, 32'd1002, 8'h00);
    push_item(CMD_EDGE, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 8'h00);
    push_item(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF8, 8'h00);
    push_item(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'h00);
    push_item(CMD_EDGE, 1'b1, 1'b0, 1'b0, 32'd1, 8'h00);
    push_item(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'd3, 8'h00);
    push_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd5, 8'h00);
    push_item(CMD_SET,  1'b1, 1'b0, 1'b0, 32'd5, 8'h00);
    push_item(CMD_PLUS, 1'b1, 1'b0, 1'b0, 32'd5, 8'h00);
    push_item(CMD_SET,  1'b0, 1'b0, 1'b0, 32'd5, 8'hAA);
    push_item(CMD_SET,  1'b1, 1'b0, 1'b0, 32'd5, 8'd17);
    ms_now = $urandom;
    fill_random(100);
    wait_idle();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph % 4)
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        3:       begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      // count, cw, ccw, reverse, snap, settle, delay, cap
      case (ph)
        1: setting = '{8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1};
        2: setting = '{8'd254, 8'd255, 8'd255, 8'd1, 8'd1, 8'd15, 8'd63, 8'd127};
        3: setting = '{8'd5, 8'd3, 8'd2, 8'd0, 8'd1, 8'd1, 8'd1, 8'd127};
        default: begin
          setting[0] = $urandom_range(1) ? $urandom_range(12, 1) : $urandom_range(254, 1);
          setting[1] = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(255, 1);
          setting[2] = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(255, 1);
          setting[3] = $urandom_range(1);
          setting[4] = $urandom_range(1);
          setting[5] = ($urandom_range(3) == 0) ? $urandom_range(15, 1) : $urandom_range(3, 1);
          setting[6] = ($urandom_range(3) == 0) ? $urandom_range(63, 1) : $urandom_range(6, 1);
          setting[7] = $urandom_range(1) ? $urandom_range(127, 1) : $urandom_range(127, 60);
        end
      endcase
      for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), setting[i]);
      @(posedge clk);
      cfg_we <= 1'b0;

      // Channel 0 was left mid-settle under long timing: it now runs past both
      // trigger points, wraps to zero and stops
      if (ph == 3)
        for (int i = 0; i < 125; i++)
          push_item(CMD_TICK, 1'b0, $urandom_range(1), $urandom_range(1), next_ms(), 8'd0);
      // Long output hold-off while requests keep coming
      if (ph == 4) hold_req = 1'b1;

      fill_random(155);
      if (ph == 2) begin
        push_item(CMD_EDGE, 1'b0, 1'b0, 1'b0, next_ms(), 8'd0);
        for (int i = 0; i < 5; i++)
          push_item(CMD_TICK, 1'b0, 1'b1, 1'b0, next_ms(), 8'd0);
      end
      wait_idle();
    end

    if (mismatch_n == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
